[hdl/trht_pkg.sv]
`default_nettype none

package trht_pkg;

  // Table depth and derived widths
  localparam int MaxEntries = 64;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int IdxW       = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;

  // Field widths
  localparam int PosW = 20;
  localparam int DimW = 19;
  localparam int TgtW = 16;
  localparam int OrdW = 16;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_e;

  // One stored rectangle
  typedef struct packed {
    logic signed [PosW-1:0] left;
    logic signed [PosW-1:0] top;
    logic        [DimW-1:0] w;
    logic        [DimW-1:0] h;
    logic        [TgtW-1:0] target;
    logic signed [OrdW-1:0] order;
  } entry_t;

  // Query token passed from cell to cell, with the best hit so far
  typedef struct packed {
    logic                   valid;
    logic signed [PosW-1:0] x;
    logic signed [PosW-1:0] y;
    logic                   found;
    logic        [TgtW-1:0] target;
    logic signed [OrdW-1:0] order;
  } token_t;

  // Per-cell control from the top level
  typedef struct packed {
    logic we;    // load the entry this cycle
    logic live;  // entry lies below the fill count
  } cell_ctl_t;

endpackage

`default_nettype wire

[hdl/trht_cell.sv]
`default_nettype none

module trht_cell (
  input  logic                clk,
  input  logic                rst,
  input  trht_pkg::cell_ctl_t ctl,
  input  trht_pkg::entry_t    wdata,
  input  trht_pkg::token_t    tok_in,
  output trht_pkg::token_t    tok_out
);

  trht_pkg::entry_t ent;
  trht_pkg::token_t tok_next;

  logic signed [trht_pkg::PosW:0] dx;
  logic signed [trht_pkg::PosW:0] dy;
  logic in_x;
  logic in_y;
  logic take;

  // Entry storage, loaded on add
  always_ff @(posedge clk) begin
    if (ctl.we) begin
      ent <= wdata;
    end
  end

  // Half-open containment: 0 <= p - origin < size
  always_comb begin
    dx   = {tok_in.x[trht_pkg::PosW-1], tok_in.x} - {ent.left[trht_pkg::PosW-1], ent.left};
    dy   = {tok_in.y[trht_pkg::PosW-1], tok_in.y} - {ent.top[trht_pkg::PosW-1], ent.top};
    in_x = !dx[trht_pkg::PosW] && (dx[trht_pkg::PosW-1:0] < {1'b0, ent.w});
    in_y = !dy[trht_pkg::PosW] && (dy[trht_pkg::PosW-1:0] < {1'b0, ent.h});
    // strictly higher order replaces: earlier entry wins ties
    take = tok_in.valid && ctl.live && in_x && in_y &&
           (!tok_in.found || (ent.order > tok_in.order));
  end

  // Token update
  always_comb begin
    tok_next = tok_in;
    if (take) begin
      tok_next.found  = 1'b1;
      tok_next.target = ent.target;
      tok_next.order  = ent.order;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

endmodule

`default_nettype wire

[hdl/topmost_rectangle_hit_test_core.sv]
`default_nettype none

// Topmost rectangle hit test. Add and clear items give no result. A query
// runs through a chain of MaxEntries cells (64), one cell per cycle, from a
// launch register to the last cell; done pulses when it leaves the last cell,
// and busy stays high from the accept through that cycle. The result is shown
// for that single cycle only and cannot be stalled; the receiver must take it
// when done is high. A miss gives hit, hit_target and hit_order all zero.
module topmost_rectangle_hit_test_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op,
  input  logic signed [trht_pkg::PosW-1:0]    pos_x,
  input  logic signed [trht_pkg::PosW-1:0]    pos_y,
  input  logic        [trht_pkg::DimW-1:0]    width,
  input  logic        [trht_pkg::DimW-1:0]    height,
  input  logic        [trht_pkg::TgtW-1:0]    in_target,
  input  logic signed [trht_pkg::OrdW-1:0]    entry_order,
  output logic                                done,
  output logic                                hit,
  output logic        [trht_pkg::TgtW-1:0]    hit_target,
  output logic signed [trht_pkg::OrdW-1:0]    hit_order
);

  localparam int N = trht_pkg::MaxEntries;

  logic                      accept;
  logic                      add_ok;
  logic [trht_pkg::CntW-1:0] entry_count;
  trht_pkg::entry_t          wdata;
  trht_pkg::token_t          chain [N+1];
  trht_pkg::cell_ctl_t       ctl   [N];
  logic [N:0]                chain_valid;

  assign accept = start && !busy;
  assign add_ok = accept && (op == trht_pkg::OP_ADD) && (in_target != '0) &&
                  (width != '0) && (height != '0) &&
                  (entry_count < trht_pkg::CntW'(N));

  // Fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (accept && (op == trht_pkg::OP_CLEAR)) begin
      entry_count <= '0;
    end else if (add_ok) begin
      entry_count <= entry_count + 1'b1;
    end
  end

  // Busy from query accept until the result leaves the chain
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept && (op == trht_pkg::OP_QUERY)) begin
      busy <= 1'b1;
    end else if (chain[N].valid) begin
      busy <= 1'b0;
    end
  end

  // Launch register feeding the first cell
  always_ff @(posedge clk) begin
    if (rst) begin
      chain[0] <= '0;
    end else begin
      chain[0].valid  <= accept && (op == trht_pkg::OP_QUERY);
      chain[0].x      <= pos_x;
      chain[0].y      <= pos_y;
      chain[0].found  <= 1'b0;
      chain[0].target <= '0;
      chain[0].order  <= '0;
    end
  end

  // Write data for an add
  always_comb begin
    wdata.left   = pos_x;
    wdata.top    = pos_y;
    wdata.w      = width;
    wdata.h      = height;
    wdata.target = in_target;
    wdata.order  = entry_order;
  end

  // Cell chain
  for (genvar i = 0; i < N; i++) begin : g_cell
    always_comb begin
      ctl[i].we   = add_ok && (entry_count == trht_pkg::CntW'(i));
      ctl[i].live = trht_pkg::CntW'(i) < entry_count;
    end

    trht_cell u_cell (
      .clk    (clk),
      .rst    (rst),
      .ctl    (ctl[i]),
      .wdata  (wdata),
      .tok_in (chain[i]),
      .tok_out(chain[i+1])
    );
  end

  for (genvar i = 0; i <= N; i++) begin : g_valid
    assign chain_valid[i] = chain[i].valid;
  end

  // Result straight from the last cell
  assign done       = chain[N].valid;
  assign hit        = chain[N].found;
  assign hit_target = chain[N].target;
  assign hit_order  = chain[N].order;

  // At most one query in the chain
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(chain_valid))
    else $error("more than one query in flight");

  // A result only comes out of a running query
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("result without a running query");

  // An accepted query keeps the block busy
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    (accept && (op == trht_pkg::OP_QUERY)) |=> busy)
    else $error("query accepted but block not busy");

  // A miss reports zero target and order
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !hit) |-> ((hit_target == '0) && (hit_order == '0)))
    else $error("miss with nonzero payload");

  // Fill count never passes the table depth
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    entry_count <= trht_pkg::CntW'(N))
    else $error("fill count beyond table depth");

endmodule

`default_nettype wire

[verif/trht_checker.sv]
`default_nettype none

// Watches the command and result ports, keeps its own copy of the
// rectangle table and checks every query result against it.
module trht_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic                             busy,
  input  logic [1:0]                       op,
  input  logic signed [trht_pkg::PosW-1:0] pos_x,
  input  logic signed [trht_pkg::PosW-1:0] pos_y,
  input  logic        [trht_pkg::DimW-1:0] width,
  input  logic        [trht_pkg::DimW-1:0] height,
  input  logic        [trht_pkg::TgtW-1:0] in_target,
  input  logic signed [trht_pkg::OrdW-1:0] entry_order,
  input  logic                             done,
  input  logic                             hit,
  input  logic        [trht_pkg::TgtW-1:0] hit_target,
  input  logic signed [trht_pkg::OrdW-1:0] hit_order,
  output int                               errors,
  output int                               pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                             hit;
    logic        [trht_pkg::TgtW-1:0] target;
    logic signed [trht_pkg::OrdW-1:0] order;
  } hit_result_t;

  trht_pkg::entry_t table_mem [trht_pkg::MaxEntries];
  int               fill_count = 0;
  int               fail_count = 0;
  hit_result_t      hit_results_q[$];

  // Topmost containing entry; ties keep the earlier entry
  function automatic hit_result_t predict_topmost(
      input logic signed [trht_pkg::PosW-1:0] qx,
      input logic signed [trht_pkg::PosW-1:0] qy);
    hit_result_t r;
    int          best;
    int          lx;
    int          ty;
    r    = '0;
    best = -1;
    for (int i = 0; i < fill_count; i++) begin
      lx = int'(table_mem[i].left);
      ty = int'(table_mem[i].top);
      if (int'(qx) >= lx && int'(qx) < lx + int'(table_mem[i].w) &&
          int'(qy) >= ty && int'(qy) < ty + int'(table_mem[i].h)) begin
        if (best < 0 || table_mem[i].order > table_mem[best].order)
          best = i;
      end
    end
    if (best >= 0) begin
      r.hit    = 1'b1;
      r.target = table_mem[best].target;
      r.order  = table_mem[best].order;
    end
    return r;
  endfunction

  always @(posedge clk) begin : mon_blk
    hit_result_t want;
    if (!rst) begin
      // results: compare with the oldest outstanding query
      if (done) begin
        if (hit_results_q.size() == 0) begin
          $display("%0t: result with no query outstanding: got hit %0b target %0d order %0d",
                   $time, hit, hit_target, hit_order);
          fail_count++;
        end else begin
          want = hit_results_q.pop_front();
          if (hit !== want.hit) begin
            $display("%0t: hit mismatch: expected %0b actual %0b", $time, want.hit, hit);
            fail_count++;
          end
          if (hit_target !== want.target) begin
            $display("%0t: hit_target mismatch: expected %0d actual %0d",
                     $time, want.target, hit_target);
            fail_count++;
          end
          if (hit_order !== want.order) begin
            $display("%0t: hit_order mismatch: expected %0d actual %0d",
                     $time, want.order, hit_order);
            fail_count++;
          end
        end
      end

      // accepted item: update the table or queue a prediction
      if (start && !busy) begin
        case (op)
          trht_pkg::OP_CLEAR: fill_count = 0;
          trht_pkg::OP_ADD: begin
            if (in_target != '0 && width != '0 && height != '0 &&
                fill_count < trht_pkg::MaxEntries) begin
              table_mem[fill_count].left   = pos_x;
              table_mem[fill_count].top    = pos_y;
              table_mem[fill_count].w      = width;
              table_mem[fill_count].h      = height;
              table_mem[fill_count].target = in_target;
              table_mem[fill_count].order  = entry_order;
              fill_count++;
            end
          end
          trht_pkg::OP_QUERY: hit_results_q.push_back(predict_topmost(pos_x, pos_y));
          default: ;  // unused code is ignored
        endcase
      end
    end
    errors  <= fail_count;
    pending <= hit_results_q.size();
  end

endmodule

`default_nettype wire

[verif/tb.sv]
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OpUnused = 2'd3;
  localparam int         AimMax   = 128;

  logic                             clk;
  logic                             rst         = 1'b1;
  logic                             start       = 1'b0;
  logic                             busy;
  logic [1:0]                       op          = trht_pkg::OP_CLEAR;
  logic signed [trht_pkg::PosW-1:0] pos_x       = '0;
  logic signed [trht_pkg::PosW-1:0] pos_y       = '0;
  logic        [trht_pkg::DimW-1:0] width       = '0;
  logic        [trht_pkg::DimW-1:0] height      = '0;
  logic        [trht_pkg::TgtW-1:0] in_target   = '0;
  logic signed [trht_pkg::OrdW-1:0] entry_order = '0;
  logic                             done;
  logic                             hit;
  logic        [trht_pkg::TgtW-1:0] hit_target;
  logic signed [trht_pkg::OrdW-1:0] hit_order;
  int                               errors;
  int                               pending;

  // sender pacing and item bookkeeping
  int idle_pct  = 0;
  int n_counted = 0;

  // rectangles added so far, used to aim queries at edges
  int aim_l [AimMax];
  int aim_t [AimMax];
  int aim_w [AimMax];
  int aim_h [AimMax];
  int n_aim = 0;

  topmost_rectangle_hit_test_core u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .width       (width),
    .height      (height),
    .in_target   (in_target),
    .entry_order (entry_order),
    .done        (done),
    .hit         (hit),
    .hit_target  (hit_target),
    .hit_order   (hit_order)
  );

  trht_checker u_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .op          (op),
    .pos_x       (pos_x),
    .pos_y       (pos_y),
    .width       (width),
    .height      (height),
    .in_target   (in_target),
    .entry_order (entry_order),
    .done        (done),
    .hit         (hit),
    .hit_target  (hit_target),
    .hit_order   (hit_order),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Present one item, hold it until accepted, then maybe idle a while
  task automatic issue_item(input logic [1:0] code, input int x, input int y,
                            input int w, input int h, input int tgt, input int ord);
    start       <= 1'b1;
    op          <= code;
    pos_x       <= x[trht_pkg::PosW-1:0];
    pos_y       <= y[trht_pkg::PosW-1:0];
    width       <= w[trht_pkg::DimW-1:0];
    height      <= h[trht_pkg::DimW-1:0];
    in_target   <= tgt[trht_pkg::TgtW-1:0];
    entry_order <= ord[trht_pkg::OrdW-1:0];
    do @(posedge clk); while (busy);
    if (code == trht_pkg::OP_CLEAR || code == trht_pkg::OP_QUERY ||
        (code == trht_pkg::OP_ADD && tgt[trht_pkg::TgtW-1:0] != '0 &&
         w[trht_pkg::DimW-1:0] != '0 && h[trht_pkg::DimW-1:0] != '0))
      n_counted++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  // Add a rectangle and, if it has nonzero size and room is left, remember it for aiming
  task automatic add_rect(input int x, input int y, input int w, input int h,
                          input int tgt, input int ord);
    if (n_aim < AimMax && w[trht_pkg::DimW-1:0] != '0 && h[trht_pkg::DimW-1:0] != '0) begin
      aim_l[n_aim] = int'($signed(x[trht_pkg::PosW-1:0]));
      aim_t[n_aim] = int'($signed(y[trht_pkg::PosW-1:0]));
      aim_w[n_aim] = int'(w[trht_pkg::DimW-1:0]);
      aim_h[n_aim] = int'(h[trht_pkg::DimW-1:0]);
      n_aim++;
    end
    issue_item(trht_pkg::OP_ADD, x, y, w, h, tgt, ord);
  endtask

  task automatic clear_table();
    n_aim = 0;
    issue_item(trht_pkg::OP_CLEAR, $urandom, $urandom, $urandom, $urandom, $urandom,
               $urandom);
  endtask

  // Coordinate near a stored edge, or anywhere inside the span
  function automatic int aim_coord(input int lo, input int span);
    case ($urandom_range(5))
      0: return lo - 1;
      1: return lo;
      2: return lo + span - 1;
      3: return lo + span;
      default: return lo + int'($urandom_range(span - 1));
    endcase
  endfunction

  initial begin
    int idle_plan [3];
    int base_x;
    int base_y;
    int n_add;
    int n_query;
    int k;
    int sel;
    int w;
    int h;
    int tgt;
    int ord;

    idle_plan = '{0, 49, 6};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, dropped adds, extremes, edges, ties, clear
    issue_item(trht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
    issue_item(OpUnused, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    add_rect(0, 0, 16, 16, 0, 1);
    add_rect(0, 0, 0, 16, 7, 1);
    add_rect(0, 0, 16, 0, 7, 1);
    issue_item(trht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
    add_rect(-524288, -524288, 524287, 524287, 65535, -32768);
    add_rect(0, 0, 32, 16, 1, 5);
    add_rect(0, 0, 32, 16, 2, 5);          // same order: the first one stays on top
    add_rect(524287, 524287, 524287, 524287, 32768, 32767);
    issue_item(trht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);
    issue_item(trht_pkg::OP_QUERY, 31, 15, 0, 0, 0, 0);
    issue_item(trht_pkg::OP_QUERY, 32, 0, 0, 0, 0, 0);
    issue_item(trht_pkg::OP_QUERY, -524288, -524288, 0, 0, 0, 0);
    issue_item(trht_pkg::OP_QUERY, -2, -2, 0, 0, 0, 0);
    issue_item(trht_pkg::OP_QUERY, -1, -1, 0, 0, 0, 0);
    issue_item(trht_pkg::OP_QUERY, 524287, 524287, 0, 0, 0, 0);
    add_rect(8, 4, 4, 4, 3, 32767);
    issue_item(trht_pkg::OP_QUERY, 8, 4, 0, 0, 0, 0);
    issue_item(trht_pkg::OP_QUERY, 12, 4, 0, 0, 0, 0);
    clear_table();
    issue_item(trht_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0);

    // random bursts: fill a table around a spot, then probe it
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = idle_plan[ph];
      while (n_counted < (ph + 1) * 433) begin
        if ($urandom_range(3) != 0)
          clear_table();
        if ($urandom_range(19) == 0)
          issue_item(OpUnused, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        base_x = int'($urandom_range(900000)) - 450000;
        base_y = int'($urandom_range(900000)) - 450000;
        n_add  = ($urandom_range(9) == 0) ? int'($urandom_range(60, 70))
                                          : int'($urandom_range(10));
        for (int a = 0; a < n_add; a++) begin
          sel = $urandom_range(99);
          w   = $urandom_range(1, 300);
          h   = $urandom_range(1, 300);
          tgt = $urandom_range(1, 65535);
          ord = $urandom_range(1) ? int'($urandom_range(3)) : int'($urandom);
          if (sel < 75) begin
            add_rect(base_x + int'($urandom_range(400)) - 200,
                     base_y + int'($urandom_range(400)) - 200, w, h, tgt, ord);
          end else if (sel < 85) begin
            case ($urandom_range(2))
              0: tgt = 0;
              1: w = 0;
              default: h = 0;
            endcase
            add_rect(base_x, base_y, w, h, tgt, ord);
          end else begin
            add_rect($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
          end
        end
        n_query = $urandom_range(1, 6);
        for (int q = 0; q < n_query; q++) begin
          sel = $urandom_range(99);
          if (n_aim > 0 && sel < 70) begin
            k = $urandom_range(n_aim - 1);
            issue_item(trht_pkg::OP_QUERY, aim_coord(aim_l[k], aim_w[k]),
                       aim_coord(aim_t[k], aim_h[k]), $urandom, $urandom,
                       $urandom, $urandom);
          end else if (sel < 90) begin
            issue_item(trht_pkg::OP_QUERY, base_x + int'($urandom_range(800)) - 400,
                       base_y + int'($urandom_range(800)) - 400, $urandom, $urandom,
                       $urandom, $urandom);
          end else begin
            issue_item(trht_pkg::OP_QUERY, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
          end
        end
      end
    end

    // drain: wait for every outstanding query, then let the block settle
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

  // run limit
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
